FILE: rtl/bpc_pkg.sv
// Shared constants, cell control types and modular arithmetic for the banded path counter.
package bpc_pkg;

	localparam int VALUE_W = 8;
	localparam int COUNT_W = 30;
	localparam int VALUE_LIMIT_DEF = 128;
	localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd128;
	localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_START,
		CELL_STEP,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

	// Reduces a sum of three residues, which stays below three times the prime.
	function automatic logic [COUNT_W-1:0] mod_reduce3(input logic [31:0] s);
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] r;
		p1 = 32'(PRIME);
		p2 = 32'(PRIME) << 1;
		if (s >= p2) begin
			r = s - p2;
		end else if (s >= p1) begin
			r = s - p1;
		end else begin
			r = s;
		end
		return r[COUNT_W-1:0];
	endfunction

endpackage

FILE: rtl/bpc_in_if.sv
// Request channel carrying one array position to the banded path counter.
interface bpc_in_if;
	import bpc_pkg::*;

	logic valid;
	logic ready;
	logic [VALUE_W-1:0] value;
	logic last;

	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface

FILE: rtl/bpc_out_if.sv
// Result channel carrying one array count from the banded path counter.
interface bpc_out_if;
	import bpc_pkg::*;

	logic valid;
	logic ready;
	logic [COUNT_W-1:0] count;

	modport source(output valid, output count, input ready);
	modport sink(input valid, input count, output ready);
endinterface

FILE: rtl/bpc_cell.sv
// One cell of the count chain: holds the count of prefixes ending in one value.
module bpc_cell import bpc_pkg::*; #(
	parameter int INDEX = 0,
	parameter int M_W = 8
) (
	input logic clk,
	input cell_ctl_t ctl,
	input logic [M_W-1:0] bound,
	input logic [COUNT_W-1:0] left,
	input logic [COUNT_W-1:0] right,
	output logic [COUNT_W-1:0] count
);

	localparam int CW = (M_W >= VALUE_W) ? M_W + 1 : VALUE_W + 1;
	localparam logic [CW-1:0] IDX = CW'(INDEX);
	localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] right_eff;
	logic [31:0] sum;
	logic in_range;
	logic right_ok;
	logic allowed;

	always_comb begin
		in_range = IDX < CW'(bound);
		right_ok = IDX1 < CW'(bound);
		// A fixed position keeps only the cell whose value it names.
		allowed = in_range && ((ctl.value == '0) || (CW'(ctl.value) == IDX1));
		right_eff = right_ok ? right : '0;
		sum = 32'(count_q) + 32'(left) + 32'(right_eff);
		unique case (ctl.op)
			CELL_HOLD: count_d = count_q;
			CELL_START: count_d = allowed ? COUNT_W'(1) : '0;
			CELL_STEP: count_d = allowed ? mod_reduce3(sum) : '0;
			CELL_SHIFT: count_d = right;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk) begin
		count_q <= count_d;
	end

	assign count = count_q;

endmodule

FILE: rtl/banded_path_count_mod_prime.sv
// Top level of the banded path counter: cell chain, drain accumulator and handshake control.
//
// The block counts arrays of values in 1..max_value whose neighbors differ by at most one,
// modulo 1000000007. A chain of VALUE_LIMIT cells holds one count per value and all cells
// update together, so after a position without the last mark the block stays ready for the
// next one. On a position marked last the cells update, then shift their counts down the chain
// into an accumulator, one cell per cycle; the hand-over state then moves the total into the
// output register when it is empty or being read. The output register lets the next array
// start while a total still waits to be taken. max_value may be written at any time the block
// has no total in progress; values above VALUE_LIMIT act as VALUE_LIMIT.
module banded_path_count_mod_prime import bpc_pkg::*; #(
	parameter int VALUE_LIMIT = VALUE_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [VALUE_W-1:0] cfg_data,
	bpc_in_if.sink in,
	bpc_out_if.source out
);

	localparam int M_W = $clog2(VALUE_LIMIT + 1);
	localparam int DW = $clog2(VALUE_LIMIT);
	localparam int CW = (M_W >= VALUE_W) ? M_W + 1 : VALUE_W + 1;
	localparam logic [CW-1:0] LIMIT_C = CW'(VALUE_LIMIT);

	typedef enum logic [1:0] {
		S_RUN,
		S_DRAIN,
		S_HAND
	} state_t;

	state_t state_q;
	logic at_start_q;
	logic out_valid_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] acc_q;
	logic [DW-1:0] drain_q;
	logic [VALUE_W-1:0] max_value_q;

	logic [M_W-1:0] bound;
	logic in_take;
	cell_ctl_t ctl;
	logic [COUNT_W:0] acc_raw;
	logic [COUNT_W-1:0] acc_sum;
	logic [COUNT_W-1:0] cell_count [VALUE_LIMIT];

	assign bound = (CW'(max_value_q) > LIMIT_C) ? M_W'(VALUE_LIMIT) : M_W'(max_value_q);
	assign in.ready = (state_q == S_RUN);
	assign in_take = in.valid && in.ready;
	assign out.valid = out_valid_q;
	assign out.count = count_q;

	always_comb begin
		ctl.value = in.value;
		if (in_take) begin
			ctl.op = at_start_q ? CELL_START : CELL_STEP;
		end else if (state_q == S_DRAIN) begin
			ctl.op = CELL_SHIFT;
		end else begin
			ctl.op = CELL_HOLD;
		end
	end

	always_comb begin
		acc_raw = {1'b0, acc_q} + {1'b0, cell_count[0]};
		acc_sum = (acc_raw >= {1'b0, PRIME}) ? COUNT_W'(acc_raw - {1'b0, PRIME})
			: acc_raw[COUNT_W-1:0];
	end

	for (genvar k = 0; k < VALUE_LIMIT; k++) begin : g_cell
		logic [COUNT_W-1:0] left_n;
		logic [COUNT_W-1:0] right_n;
		if (k == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = cell_count[k-1];
		end
		if (k == VALUE_LIMIT - 1) begin : g_end
			assign right_n = '0;
		end else begin : g_mid_r
			assign right_n = cell_count[k+1];
		end
		bpc_cell #(
			.INDEX(k),
			.M_W(M_W)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.bound(bound),
			.left(left_n),
			.right(right_n),
			.count(cell_count[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			at_start_q <= 1'b1;
			out_valid_q <= 1'b0;
			count_q <= '0;
			acc_q <= '0;
			drain_q <= '0;
			max_value_q <= MAX_VALUE_RESET;
		end else begin
			if (cfg_we) begin
				max_value_q <= cfg_data;
			end
			// In the hand-over state the output flag is set below instead.
			if (out.valid && out.ready && state_q != S_HAND) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (in_take) begin
						at_start_q <= in.last;
						if (in.last) begin
							acc_q <= '0;
							drain_q <= DW'(VALUE_LIMIT - 1);
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					acc_q <= acc_sum;
					if (drain_q == '0) begin
						state_q <= S_HAND;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				S_HAND: begin
					// The total waits here until the previous one has been taken.
					if (!out_valid_q || out.ready) begin
						count_q <= acc_q;
						out_valid_q <= 1'b1;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && in.last |=> state_q == S_DRAIN)
		else $error("last request did not start the drain");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN && drain_q == '0 |=> state_q == S_HAND)
		else $error("drain did not end after the final cell");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_RUN |-> acc_q < PRIME)
		else $error("accumulator left its residue range");

	a_out_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> count_q < PRIME)
		else $error("result count left its residue range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HAND && out_valid_q && !out.ready |=> state_q == S_HAND)
		else $error("total handed over while the previous one was pending");

endmodule

FILE: verif/bpc_count_checker.sv
// Checker for the banded path counter: tracks the count vector and compares every total.
`timescale 1ns / 100ps

module bpc_count_checker import bpc_pkg::*; #(
	parameter int VALUE_LIMIT = VALUE_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [VALUE_W-1:0] cfg_data,
	input logic req_valid,
	input logic req_ready,
	input logic [VALUE_W-1:0] req_value,
	input logic req_last,
	input logic res_valid,
	input logic res_ready,
	input logic [COUNT_W-1:0] res_count,
	output int mismatches,
	output int due
);

	logic [COUNT_W-1:0] ways [VALUE_LIMIT];
	logic [COUNT_W-1:0] next_ways [VALUE_LIMIT];
	logic [VALUE_W-1:0] bound_reg;
	bit fresh;
	logic [COUNT_W-1:0] expected_counts [$];
	logic [COUNT_W-1:0] oldest;

	// Folds one array position into the count vector and queues the total on the last one.
	task automatic predict_position(input logic [VALUE_W-1:0] v, input logic l);
		int m;
		longint unsigned s;
		longint unsigned total;
		m = (int'(bound_reg) > VALUE_LIMIT) ? VALUE_LIMIT : int'(bound_reg);
		if (fresh) begin
			for (int k = 0; k < VALUE_LIMIT; k++) ways[k] = '0;
			if (v == 0) begin
				for (int k = 0; k < m; k++) ways[k] = COUNT_W'(1);
			end else if (int'(v) <= m) begin
				ways[v - 1] = COUNT_W'(1);
			end
			fresh = 1'b0;
		end else begin
			for (int k = 0; k < VALUE_LIMIT; k++) begin
				s = 0;
				// Cells at or above the bound neither hold a count nor feed a neighbor.
				if (k < m) begin
					s = ways[k];
					if (k > 0) s += ways[k - 1];
					if (k + 1 < m) s += ways[k + 1];
					s %= PRIME;
				end
				next_ways[k] = s[COUNT_W-1:0];
				if (v != 0 && k + 1 != int'(v)) next_ways[k] = '0;
			end
			ways = next_ways;
		end
		if (l) begin
			total = 0;
			for (int k = 0; k < m; k++) total = (total + ways[k]) % PRIME;
			expected_counts.push_back(total[COUNT_W-1:0]);
			fresh = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_reg = MAX_VALUE_RESET;
			fresh = 1'b1;
			expected_counts.delete();
			mismatches = 0;
			due = 0;
			for (int k = 0; k < VALUE_LIMIT; k++) ways[k] = '0;
		end else begin
			if (cfg_we) bound_reg = cfg_data;
			// The result is checked before this edge's request so it never meets its own total.
			if (res_valid && res_ready) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected count: expected none, actual %0d", $time, res_count);
					mismatches++;
				end else begin
					oldest = expected_counts.pop_front();
					if (oldest !== res_count) begin
						$display("%0t: count mismatch: expected %0d, actual %0d",
							$time, oldest, res_count);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) predict_position(req_value, req_last);
			due = expected_counts.size();
		end
	end

endmodule

FILE: verif/banded_path_count_mod_prime_tb.sv
// Top of the banded path counter testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module banded_path_count_mod_prime_tb;
	import bpc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [VALUE_W-1:0] cfg_data;
	int idle_pct;
	int stall_pct;
	int hold_len;
	int cur_bound;
	int mismatches;
	int due;

	bpc_in_if req_ch();
	bpc_out_if res_ch();

	banded_path_count_mod_prime DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in(req_ch),
		.out(res_ch)
	);

	bpc_count_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_value(req_ch.value),
		.req_last(req_ch.last),
		.res_valid(res_ch.valid),
		.res_ready(res_ch.ready),
		.res_count(res_ch.count),
		.mismatches(mismatches),
		.due(due)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when the stimulus asks for one.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_position(input logic [VALUE_W-1:0] v, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.value <= VALUE_W'($urandom);
			req_ch.last <= 1'($urandom);
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.value <= v;
		req_ch.last <= l;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Waits until every total is out, then lets a full drain pass.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due != 0) @(posedge clk);
		repeat (2 * VALUE_LIMIT_DEF + 8) @(posedge clk);
	endtask

	task automatic write_bound(input int v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= VALUE_W'(v);
		cur_bound = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly consistent arrays: fixed values wander by at most one; some noise and broken ones.
	task automatic send_array(input int len, input bit close);
		int m;
		int pos;
		int kind;
		logic [VALUE_W-1:0] v;
		m = (cur_bound > VALUE_LIMIT_DEF) ? VALUE_LIMIT_DEF : cur_bound;
		if (m < 1) m = 1;
		kind = $urandom_range(9);
		pos = $urandom_range(m, 1);
		for (int i = 0; i < len; i++) begin
			if (kind == 0) begin
				v = VALUE_W'($urandom_range(VALUE_LIMIT_DEF, 0));
			end else if ($urandom_range(99) < 60) begin
				v = '0;
			end else begin
				pos = pos + $urandom_range(2) - 1;
				if (pos < 1) pos = 1;
				if (pos > m) pos = m;
				v = VALUE_W'(pos);
				if (kind == 9 && $urandom_range(3) == 0) begin
					v = VALUE_W'($urandom_range(VALUE_LIMIT_DEF, 0));
				end
			end
			send_position(v, close && i == len - 1);
		end
	endtask

	function automatic int pick_length();
		if ($urandom_range(9) == 0) return $urandom_range(40, 16);
		return $urandom_range(10, 1);
	endfunction

	initial begin
		int plan [8];
		int idle_set [4];
		int stall_set [4];
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.value = '0;
		req_ch.last = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_len = 0;
		cur_bound = MAX_VALUE_RESET;
		idle_set = '{0, 48, 0, 16};
		stall_set = '{0, 0, 48, 16};
		plan = '{128, 2, $urandom_range(126, 3), 255, 1, $urandom_range(126, 3), 127,
			$urandom_range(126, 3)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single positions, edges of the value range, and an inconsistent pair.
		send_position(8'd0, 1'b1);
		send_position(8'd128, 1'b1);
		send_position(8'd1, 1'b1);
		send_position(8'd0, 1'b0);
		send_position(8'd0, 1'b1);
		send_position(8'd1, 1'b0);
		send_position(8'd0, 1'b0);
		send_position(8'd2, 1'b1);
		send_position(8'd128, 1'b0);
		send_position(8'd127, 1'b0);
		send_position(8'd0, 1'b1);
		send_position(8'd5, 1'b0);
		send_position(8'd9, 1'b1);
		// A zero bound allows no value at all.
		write_bound(0);
		send_position(8'd0, 1'b1);
		send_position(8'd3, 1'b1);
		// Bounds above the cell count saturate.
		write_bound(255);
		send_position(8'd0, 1'b0);
		send_position(8'd128, 1'b1);
		write_bound(1);
		send_position(8'd0, 1'b0);
		send_position(8'd0, 1'b1);
		send_position(8'd2, 1'b1);
		// The bound shrinks in the middle of an array.
		write_bound(10);
		send_position(8'd0, 1'b0);
		send_position(8'd0, 1'b0);
		write_bound(3);
		send_position(8'd0, 1'b1);

		for (int s = 0; s < 8; s++) begin
			idle_pct = idle_set[s / 2];
			stall_pct = stall_set[s / 2];
			write_bound(plan[s]);
			sent = 0;
			while (sent < 115) begin
				len = pick_length();
				send_array(len, 1'b1);
				sent += len;
				if (s == 3 && sent > 50 && sent <= 50 + len) settle();
			end
			if (s == 0) begin
				// Fill the block behind a stalled receiver.
				hold_len = 800;
				for (int a = 0; a < 12; a++) send_array($urandom_range(2, 1), 1'b1);
			end
			// Leave an array open so the next bound applies to it midway.
			send_array($urandom_range(3, 1), 1'b0);
		end
		send_array(2, 1'b1);

		settle();
		if (mismatches == 0 && due == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
